FILE: design/swwsa_pkg.sv
// ----------------------------------------------------------------------------
// swwsa_pkg
// Shared widths, sine constants, register codes and the config bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swwsa_pkg;

   // Sizing
   localparam int COORD_BITS = 12;
   localparam int SINE_BITS  = 16;

   // Register field widths
   localparam int ORIENT_W   = 16;
   localparam int PHASE_W    = 32;
   localparam int COEF_W     = 21;
   localparam int FRAME_W    = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Projection and phase
   localparam int MUL_W      = COORD_BITS + 1 + ORIENT_W;
   localparam int PROJ_W     = MUL_W + 1;
   localparam int PROD_SHIFT = ORIENT_W - 1;
   localparam int PROD_W     = PHASE_W + PROD_SHIFT;

   // Sine polynomial, Q30
   localparam int Q_SHIFT  = 30;
   localparam int Z_W      = 31;
   localparam int Z2_W     = 31;
   localparam int SIN_A_W  = 31;
   localparam int SIN_B_W  = 30;
   localparam int SIN_C_W  = 27;
   localparam int T_W      = SIN_C_W + Z2_W - Q_SHIFT;
   localparam int V_W      = SIN_B_W + Z2_W - Q_SHIFT;
   localparam int S_W      = SIN_A_W + Z_W - Q_SHIFT;
   localparam int AMP_W    = SINE_BITS - 1;
   localparam int MP_W     = S_W + AMP_W + 1;
   localparam int M_W      = SINE_BITS;
   localparam int SINE_W   = SINE_BITS + 1;

   localparam logic [Z_W-1:0]     Q30_ONE  = Z_W'(1) << Q_SHIFT;
   localparam logic [SIN_A_W-1:0] SIN_A    = 31'd1686629713;
   localparam logic [SIN_B_W-1:0] SIN_B    = 30'd688904866;
   localparam logic [SIN_C_W-1:0] SIN_C    = 27'd76016977;
   localparam logic [AMP_W-1:0]   SINE_AMP = {AMP_W{1'b1}};
   localparam logic [MP_W-1:0]    Q30_HALF = MP_W'(1) << (Q_SHIFT - 1);

   // Displacement
   localparam int FRAC_BITS = SINE_BITS - 1 + 8;
   localparam int DPROD_W   = SINE_W + COEF_W;
   localparam int VAL_BASE  = (COORD_BITS + FRAC_BITS > DPROD_W) ?
                              COORD_BITS + FRAC_BITS : DPROD_W;
   localparam int VAL_W     = VAL_BASE + 2;
   localparam int SH_W      = VAL_W - FRAC_BITS;
   localparam logic signed [VAL_W-1:0] ROUND_HALF = VAL_W'(1) << (FRAC_BITS - 1);

   // Frame limit
   localparam int LIM_W = (COORD_BITS + 1 > FRAME_W) ? COORD_BITS + 1 : FRAME_W;
   localparam logic [LIM_W-1:0]   LIM_CAP     = LIM_W'(1) << COORD_BITS;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd4096;

   // Register reset values
   localparam logic signed [ORIENT_W-1:0] COS_RESET = 16'sd32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_ORIENT   = 3'd0,
      CSR_SIN_ORIENT   = 3'd1,
      CSR_WAVE_STEP    = 3'd2,
      CSR_TIME_PHASE   = 3'd3,
      CSR_DISP_COEF_X  = 3'd4,
      CSR_DISP_COEF_Y  = 3'd5,
      CSR_FRAME_WIDTH  = 3'd6,
      CSR_FRAME_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [ORIENT_W-1:0] cos_orient;
      logic signed [ORIENT_W-1:0] sin_orient;
      logic [PHASE_W-1:0]         wave_step;
      logic [PHASE_W-1:0]         time_phase;
      logic signed [COEF_W-1:0]   disp_coef_x;
      logic signed [COEF_W-1:0]   disp_coef_y;
      logic [COORD_BITS-1:0]      limit_x;
      logic [COORD_BITS-1:0]      limit_y;
   } cfg_type;

   // Largest legal coordinate for a frame size; zero acts as one.
   function automatic logic [COORD_BITS-1:0] frame_limit(input logic [FRAME_W-1:0] size);
      logic [LIM_W-1:0] sz;
      sz = LIM_W'(size);
      if (sz == '0) begin
         frame_limit = '0;
      end else if (sz > LIM_CAP) begin
         frame_limit = '1;
      end else begin
         frame_limit = COORD_BITS'(sz - LIM_W'(1));
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/swwsa_if.sv
// ----------------------------------------------------------------------------
// swwsa_if
// Valid/ready channels: pixel coordinate in, sample coordinate out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swwsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [swwsa_pkg::COORD_BITS-1:0]    pixel_x;
   logic [swwsa_pkg::COORD_BITS-1:0]    pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface swwsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [swwsa_pkg::COORD_BITS-1:0]    sample_x;
   logic [swwsa_pkg::COORD_BITS-1:0]    sample_y;

   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

`default_nettype wire

FILE: design/swwsa_csr.sv
// ----------------------------------------------------------------------------
// swwsa_csr
// Configuration registers; frame sizes are stored as clamp limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swwsa_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [swwsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [swwsa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output swwsa_pkg::cfg_type                     cfg
);
   import swwsa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COS_ORIENT:   cfg_in.cos_orient  = ORIENT_W'(csr_wdata);
            CSR_SIN_ORIENT:   cfg_in.sin_orient  = ORIENT_W'(csr_wdata);
            CSR_WAVE_STEP:    cfg_in.wave_step   = PHASE_W'(csr_wdata);
            CSR_TIME_PHASE:   cfg_in.time_phase  = PHASE_W'(csr_wdata);
            CSR_DISP_COEF_X:  cfg_in.disp_coef_x = COEF_W'(csr_wdata);
            CSR_DISP_COEF_Y:  cfg_in.disp_coef_y = COEF_W'(csr_wdata);
            CSR_FRAME_WIDTH:  cfg_in.limit_x     = frame_limit(FRAME_W'(csr_wdata));
            CSR_FRAME_HEIGHT: cfg_in.limit_y     = frame_limit(FRAME_W'(csr_wdata));
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_orient  <= COS_RESET;
         cfg_ff.sin_orient  <= '0;
         cfg_ff.wave_step   <= '0;
         cfg_ff.time_phase  <= '0;
         cfg_ff.disp_coef_x <= '0;
         cfg_ff.disp_coef_y <= '0;
         cfg_ff.limit_x     <= frame_limit(FRAME_RESET);
         cfg_ff.limit_y     <= frame_limit(FRAME_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/swwsa_phase.sv
// ----------------------------------------------------------------------------
// swwsa_phase
// Four-stage pipe: orientation products, projection, scale, add time phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swwsa_phase (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire swwsa_pkg::cfg_type                cfg,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_x,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_y,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [swwsa_pkg::PHASE_W-1:0]          out_phase,
   output logic [swwsa_pkg::COORD_BITS-1:0]       out_x,
   output logic [swwsa_pkg::COORD_BITS-1:0]       out_y
);
   import swwsa_pkg::*;

   localparam int NST = 4;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST:0]   en;

   logic signed [MUL_W-1:0]  mcos_ff, msin_ff;
   logic signed [PROJ_W-1:0] proj_ff;
   logic [PHASE_W-1:0]       prod_ff, phase_ff;
   logic [COORD_BITS-1:0]    x_ff [NST];
   logic [COORD_BITS-1:0]    y_ff [NST];

   logic signed [PROD_W-1:0] prod_full;

   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NST; k++) begin
         if (!en[k]) begin
            vld_in[k] = vld_ff[k];
         end else if (k == 0) begin
            vld_in[k] = in_valid;
         end else begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // only product bits PROD_SHIFT up to PROD_SHIFT+PHASE_W-1 reach the phase
   assign prod_full = proj_ff * $signed({1'b0, cfg.wave_step});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mcos_ff <= $signed({1'b0, in_x}) * cfg.cos_orient;
         msin_ff <= $signed({1'b0, in_y}) * cfg.sin_orient;
         x_ff[0] <= in_x;
         y_ff[0] <= in_y;
      end
      if (en[1]) begin
         proj_ff <= mcos_ff + msin_ff;
         x_ff[1] <= x_ff[0];
         y_ff[1] <= y_ff[0];
      end
      if (en[2]) begin
         prod_ff <= prod_full[PROD_SHIFT +: PHASE_W];
         x_ff[2] <= x_ff[1];
         y_ff[2] <= y_ff[1];
      end
      if (en[3]) begin
         phase_ff <= prod_ff + cfg.time_phase;
         x_ff[3]  <= x_ff[2];
         y_ff[3]  <= y_ff[2];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NST-1];
   assign out_phase = phase_ff;
   assign out_x     = x_ff[NST-1];
   assign out_y     = y_ff[NST-1];

endmodule

`default_nettype wire

FILE: design/swwsa_sine.sv
// ----------------------------------------------------------------------------
// swwsa_sine
// Seven-stage odd polynomial sine of a 32-bit turn phase, at most one multiply a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swwsa_sine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [swwsa_pkg::PHASE_W-1:0]     in_phase,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_x,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_y,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [swwsa_pkg::SINE_W-1:0]    out_sine,
   output logic [swwsa_pkg::COORD_BITS-1:0]       out_x,
   output logic [swwsa_pkg::COORD_BITS-1:0]       out_y
);
   import swwsa_pkg::*;

   localparam int NST = 7;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST:0]   en;

   logic [1:0]            q_ff [NST-1];
   logic [COORD_BITS-1:0] x_ff [NST];
   logic [COORD_BITS-1:0] y_ff [NST];

   logic [Z_W-1:0]  z_ff [4];
   logic [Z2_W-1:0] z2_ff [2];
   logic [T_W-1:0]  t_ff;
   logic [V_W-1:0]  v_ff;
   logic [S_W-1:0]  s_ff;
   logic [M_W-1:0]  m_ff;
   logic signed [SINE_W-1:0] sine_ff;

   logic [Z_W-1:0]                 f_ext, z_in;
   logic [2*Z_W-1:0]               zz;
   logic [SIN_C_W+Z2_W-1:0]        tp;
   logic [SIN_B_W-1:0]             bt;
   logic [SIN_B_W+Z2_W-1:0]        vp;
   logic [SIN_A_W-1:0]             av;
   logic [SIN_A_W+Z_W-1:0]         sp;
   logic [MP_W-1:0]                mp;

   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NST; k++) begin
         if (!en[k]) begin
            vld_in[k] = vld_ff[k];
         end else if (k == 0) begin
            vld_in[k] = in_valid;
         end else begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // odd quadrants mirror the angle
   assign f_ext = Z_W'(in_phase[Q_SHIFT-1:0]);
   assign z_in  = in_phase[Q_SHIFT] ? (Q30_ONE - f_ext) : f_ext;
   assign zz    = z_ff[0] * z_ff[0];
   assign tp    = SIN_C * z2_ff[0];
   assign bt    = SIN_B - SIN_B_W'(t_ff);
   assign vp    = bt * z2_ff[1];
   assign av    = SIN_A - SIN_A_W'(v_ff);
   assign sp    = av * z_ff[3];
   assign mp    = MP_W'(s_ff) * MP_W'(SINE_AMP) + Q30_HALF;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         z_ff[0] <= z_in;
         q_ff[0] <= in_phase[PHASE_W-1 -: 2];
         x_ff[0] <= in_x;
         y_ff[0] <= in_y;
      end
      if (en[1]) begin
         z2_ff[0] <= zz[Q_SHIFT +: Z2_W];
         z_ff[1]  <= z_ff[0];
         q_ff[1]  <= q_ff[0];
         x_ff[1]  <= x_ff[0];
         y_ff[1]  <= y_ff[0];
      end
      if (en[2]) begin
         t_ff     <= tp[Q_SHIFT +: T_W];
         z2_ff[1] <= z2_ff[0];
         z_ff[2]  <= z_ff[1];
         q_ff[2]  <= q_ff[1];
         x_ff[2]  <= x_ff[1];
         y_ff[2]  <= y_ff[1];
      end
      if (en[3]) begin
         v_ff    <= vp[Q_SHIFT +: V_W];
         z_ff[3] <= z_ff[2];
         q_ff[3] <= q_ff[2];
         x_ff[3] <= x_ff[2];
         y_ff[3] <= y_ff[2];
      end
      if (en[4]) begin
         s_ff    <= sp[Q_SHIFT +: S_W];
         q_ff[4] <= q_ff[3];
         x_ff[4] <= x_ff[3];
         y_ff[4] <= y_ff[3];
      end
      if (en[5]) begin
         m_ff    <= mp[Q_SHIFT +: M_W];
         q_ff[5] <= q_ff[4];
         x_ff[5] <= x_ff[4];
         y_ff[5] <= y_ff[4];
      end
      if (en[6]) begin
         // lower half-turn positive, upper negative
         sine_ff <= q_ff[5][1] ? -$signed({1'b0, m_ff}) : $signed({1'b0, m_ff});
         x_ff[6] <= x_ff[5];
         y_ff[6] <= y_ff[5];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NST-1];
   assign out_sine  = sine_ff;
   assign out_x     = x_ff[NST-1];
   assign out_y     = y_ff[NST-1];

endmodule

`default_nettype wire

FILE: design/swwsa_disp.sv
// ----------------------------------------------------------------------------
// swwsa_disp
// Three-stage displacement: scale by coefficients, round half up, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swwsa_disp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire swwsa_pkg::cfg_type                cfg,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [swwsa_pkg::SINE_W-1:0] in_sine,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_x,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  in_y,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [swwsa_pkg::COORD_BITS-1:0]       sample_x,
   output logic [swwsa_pkg::COORD_BITS-1:0]       sample_y
);
   import swwsa_pkg::*;

   localparam int NST = 3;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST:0]   en;

   logic signed [DPROD_W-1:0] dx_ff, dy_ff;
   logic [COORD_BITS-1:0]     x_ff, y_ff;
   logic signed [SH_W-1:0]    sx_ff, sy_ff;
   logic [COORD_BITS-1:0]     smp_x_ff, smp_y_ff;

   logic signed [VAL_W-1:0]   vx, vy;
   logic [COORD_BITS-1:0]     cx, cy;

   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NST; k++) begin
         if (!en[k]) begin
            vld_in[k] = vld_ff[k];
         end else if (k == 0) begin
            vld_in[k] = in_valid;
         end else begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // x moves against the sine, y with it
   assign vx = $signed({{(VAL_W-COORD_BITS-FRAC_BITS){1'b0}}, x_ff, {FRAC_BITS{1'b0}}})
               - VAL_W'(dx_ff) + ROUND_HALF;
   assign vy = $signed({{(VAL_W-COORD_BITS-FRAC_BITS){1'b0}}, y_ff, {FRAC_BITS{1'b0}}})
               + VAL_W'(dy_ff) + ROUND_HALF;

   always_comb begin
      if (sx_ff[SH_W-1]) begin
         cx = '0;
      end else if ($unsigned(sx_ff) > SH_W'(cfg.limit_x)) begin
         cx = cfg.limit_x;
      end else begin
         cx = sx_ff[COORD_BITS-1:0];
      end
      if (sy_ff[SH_W-1]) begin
         cy = '0;
      end else if ($unsigned(sy_ff) > SH_W'(cfg.limit_y)) begin
         cy = cfg.limit_y;
      end else begin
         cy = sy_ff[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_ff <= in_sine * cfg.disp_coef_x;
         dy_ff <= in_sine * cfg.disp_coef_y;
         x_ff  <= in_x;
         y_ff  <= in_y;
      end
      if (en[1]) begin
         // dropping the fraction bits floors
         sx_ff <= vx[VAL_W-1:FRAC_BITS];
         sy_ff <= vy[VAL_W-1:FRAC_BITS];
      end
      if (en[2]) begin
         smp_x_ff <= cx;
         smp_y_ff <= cy;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NST-1];
   assign sample_x  = smp_x_ff;
   assign sample_y  = smp_y_ff;

endmodule

`default_nettype wire

FILE: design/sine_wave_warp_sample_address.sv
// ----------------------------------------------------------------------------
// sine_wave_warp_sample_address
// Sine-wave warp source address generator, nearest-neighbor sampling.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one output pixel (pixel_x, pixel_y) per word; rsp_chan
//  returns the source pixel (sample_x, sample_y) to fetch, one word per
//  request word, in order. Both are valid/ready; a word moves when both high.
//  The csr_* port writes one register per cycle with csr_wr_en high; write
//  only while the pipe is empty.
//  The pipe is 14 stages: 4 in the phase pipe, 7 in the sine pipe, 3 in
//  displacement and clamp. Throughput is one word per cycle while rsp_chan
//  takes words; the pipe accepts a new word every clock while req_chan.ready
//  is high.
//  When rsp_chan stalls, the output register holds its word and the stages
//  behind it keep filling their empty slots; req_chan.ready falls only once
//  every stage holds a word. Nothing is dropped or repeated on a stall.
//  Synchronous reset empties the pipe and loads the register defaults:
//  orientation along x, no step, no displacement, 4096x4096 frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sine_wave_warp_sample_address (
   input  wire logic                              clock,
   input  wire logic                              reset,
   swwsa_req_if.sink                              req_chan,
   swwsa_rsp_if.source                            rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [swwsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [swwsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import swwsa_pkg::*;

   cfg_type cfg;

   // phase -> sine
   logic                  ph_valid, ph_ready;
   logic [PHASE_W-1:0]    ph_phase;
   logic [COORD_BITS-1:0] ph_x, ph_y;

   // sine -> displacement
   logic                     sn_valid, sn_ready;
   logic signed [SINE_W-1:0] sn_sine;
   logic [COORD_BITS-1:0]    sn_x, sn_y;

   // Register file; frame sizes are turned into clamp limits on write.
   swwsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Projection onto wave direction, scaled to turns plus time phase.
   swwsa_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_x      (req_chan.pixel_x),
      .in_y      (req_chan.pixel_y),
      .out_valid (ph_valid),
      .out_ready (ph_ready),
      .out_phase (ph_phase),
      .out_x     (ph_x),
      .out_y     (ph_y)
   );

   // Q2.15 sine of the phase.
   swwsa_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ph_valid),
      .in_ready  (ph_ready),
      .in_phase  (ph_phase),
      .in_x      (ph_x),
      .in_y      (ph_y),
      .out_valid (sn_valid),
      .out_ready (sn_ready),
      .out_sine  (sn_sine),
      .out_x     (sn_x),
      .out_y     (sn_y)
   );

   // Displace, round half up, clamp; last stage is the output register.
   swwsa_disp u_disp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (sn_valid),
      .in_ready  (sn_ready),
      .in_sine   (sn_sine),
      .in_x      (sn_x),
      .in_y      (sn_y),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .sample_x  (rsp_chan.sample_x),
      .sample_y  (rsp_chan.sample_y)
   );

endmodule

`default_nettype wire

FILE: design/swwsa_checker.sv
// ----------------------------------------------------------------------------
// swwsa_checker
// Port-level checks for the warp address generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swwsa_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  sample_x,
   input  wire logic [swwsa_pkg::COORD_BITS-1:0]  sample_y
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // request side only backs up while a response is held valid and not taken
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(sample_x) && $stable(sample_y)))
      else $error("response word changed while stalled");

endmodule

bind sine_wave_warp_sample_address swwsa_checker u_swwsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .sample_x  (rsp_chan.sample_x),
   .sample_y  (rsp_chan.sample_y)
);

`default_nettype wire
